>>> rtl/wdt_pkg.sv
// types and constants shared by the watchdog with tick generator
package wdt_pkg;

  typedef struct packed {
    logic [1:0]  command;
    logic [13:0] address;
    logic [31:0] write_data;
    logic [15:0] cycles_passed;
  } wdt_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        watchdog_reset;
    logic [31:0] tick_count;
  } wdt_rsp_t;

  // request commands
  localparam logic [1:0] CMD_READ    = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;

  // write aliases, address bits 13:12
  localparam logic [1:0] ALIAS_NORMAL = 2'd0;
  localparam logic [1:0] ALIAS_XOR    = 2'd1;
  localparam logic [1:0] ALIAS_SET    = 2'd2;
  localparam logic [1:0] ALIAS_CLEAR  = 2'd3;

  // register offsets
  localparam logic [11:0] OFF_CTRL   = 12'h000;
  localparam logic [11:0] OFF_LOAD   = 12'h004;
  localparam logic [11:0] OFF_SCR0   = 12'h00C;
  localparam logic [11:0] OFF_SCRMAX = 12'h028;
  localparam logic [11:0] OFF_TICK   = 12'h02C;

  localparam logic [31:0] CTRL_RESET      = 32'h0700_0000;
  localparam logic [31:0] CTRL_WRITE_MASK = 32'hC700_0000;
  localparam int          CTRL_ENABLE_BIT = 30;
  localparam logic [31:0] TIME_MASK       = 32'h00FF_FFFF;
  localparam logic [9:0]  TICK_RESET      = 10'h200;
  localparam int          TICK_ENABLE_BIT = 9;
  localparam logic [31:0] TICK_RUNNING    = 32'h0000_0400;
  localparam int          PHASE_SHIFT     = 11;

  // width of phase + cycles, one quotient bit per divider step
  localparam int SUM_W = 17;

endpackage

>>> rtl/watchdog_with_tick_generator.sv
// Watchdog with tick generator: register file, tick divider and countdown
//
// Requests arrive on req_valid / req_stall / req and results leave on
// rsp_valid / rsp_stall / rsp; each channel moves an item on a clock edge
// with valid high and stall low. Every request gives exactly one result.
// A request is a bus read, a bus write or an advance by a number of
// reference cycles. Requests are taken one at a time: req_stall is high
// from the edge that takes a request until its result is loaded into the
// output register.
// Reads, writes and advances that make no division go from acceptance
// straight to the final state. An advance with a non-zero divisor runs a
// restoring divider over the 17-bit sum of phase and cycles, one quotient
// bit per cycle through a single shared subtractor, before the final state.
// The result sits in an output register; while rsp_stall holds it, the
// next request may be taken but its result waits in the final state
// until the register is free.
// Synchronous reset clears the control registers to their reset values;
// scratch words are left undefined until written.
module watchdog_with_tick_generator #(
  parameter int SCRATCH_COUNT       = 8,
  parameter int MAX_CYCLES_PER_STEP = 65535
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  wdt_pkg::wdt_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output wdt_pkg::wdt_rsp_t rsp
);
  import wdt_pkg::*;

  localparam int SCR_IW = (SCRATCH_COUNT > 1) ? $clog2(SCRATCH_COUNT) : 1;
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  wdt_req_t          item;
  logic              adv;
  logic              adv_div;

  logic [31:0] ctrl;
  logic [9:0]  tick_setup;
  logic [23:0] countdown;
  logic [8:0]  phase;
  logic [31:0] tick_total;
  logic [31:0] scratch [SCRATCH_COUNT];

  // divider working registers
  logic [SUM_W-1:0] quo;
  logic [8:0]       rem;

  function automatic logic [31:0] apply_alias(input logic [31:0] cur, input logic [31:0] data,
                                              input logic [1:0] sel);
    logic [31:0] res;
    case (sel)
      ALIAS_NORMAL: res = data;
      ALIAS_XOR:    res = cur ^ data;
      ALIAS_SET:    res = cur | data;
      ALIAS_CLEAR:  res = cur & ~data;
      default:      res = data;
    endcase
    return res;
  endfunction

  // request side
  logic             take;
  logic [15:0]      cyc;
  logic [8:0]       req_div;
  logic             req_adv;
  logic [SUM_W-1:0] req_sum;

  assign req_stall = (state != ST_IDLE);
  assign take      = req_valid && !req_stall;
  assign cyc       = (32'(req.cycles_passed) > 32'(MAX_CYCLES_PER_STEP)) ?
                     16'(MAX_CYCLES_PER_STEP) : req.cycles_passed;
  assign req_div   = tick_setup[8:0];
  assign req_adv   = (req.command == CMD_ADVANCE) && (cyc != 16'd0) &&
                     tick_setup[TICK_ENABLE_BIT];
  assign req_sum   = SUM_W'(phase) + SUM_W'(cyc);

  // shared subtractor of the divider
  logic [9:0] trial;
  logic [9:0] diff;
  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, tick_setup[8:0]};

  // decode of the held request
  logic [11:0]       off;
  logic [1:0]        alias_sel;
  logic [11:0]       scr_rel;
  logic [2:0]        scr_idx3;
  logic              scr_hit;
  logic [SCR_IW-1:0] scr_idx;

  assign off       = item.address[11:0];
  assign alias_sel = item.address[13:12];
  assign scr_rel   = off - OFF_SCR0;
  assign scr_idx3  = scr_rel[4:2];
  assign scr_hit   = (off >= OFF_SCR0) && (off <= OFF_SCRMAX) && (off[1:0] == 2'b00) &&
                     (32'(scr_idx3) < 32'(SCRATCH_COUNT));
  assign scr_idx   = scr_idx3[SCR_IW-1:0];

  logic [31:0] rd_val;
  always_comb begin
    rd_val = '0;
    if (alias_sel == ALIAS_NORMAL) begin
      if (off == OFF_CTRL) begin
        rd_val = ctrl | {8'd0, countdown};
      end else if (off == OFF_TICK) begin
        rd_val = 32'(tick_setup) | TICK_RUNNING | (32'(phase) << PHASE_SHIFT);
      end else if (scr_hit) begin
        rd_val = scratch[scr_idx];
      end
    end
  end

  // finishing arithmetic for an advance
  logic [SUM_W-1:0] ticks;
  logic [23:0]      dec;
  logic [23:0]      cd_next;
  logic             count_down;
  logic             fired;

  assign ticks      = adv ? quo : '0;
  assign dec        = 24'({ticks, 1'b0});
  assign count_down = (ticks != '0) && ctrl[CTRL_ENABLE_BIT];
  assign cd_next    = (dec > countdown) ? 24'd0 : (countdown - dec);
  assign fired      = count_down && (cd_next == 24'd0);

  logic finish;
  assign finish = (state == ST_FIN) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= '0;
      adv        <= 1'b0;
      adv_div    <= 1'b0;
      ctrl       <= CTRL_RESET;
      tick_setup <= TICK_RESET;
      countdown  <= '0;
      phase      <= '0;
      tick_total <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !finish) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            adv     <= req_adv;
            adv_div <= req_adv && (req_div != 9'd0);
            step    <= '0;
            state   <= (req_adv && (req_div != 9'd0)) ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= ST_FIN;
          end
          step <= step + 1'b1;
        end
        ST_FIN: begin
          if (finish) begin
            state     <= ST_IDLE;
            rsp_valid <= 1'b1;
            if (item.command == CMD_WRITE) begin
              if (off == OFF_CTRL) begin
                ctrl <= apply_alias(ctrl, item.write_data & CTRL_WRITE_MASK, alias_sel) &
                        CTRL_WRITE_MASK;
              end else if (off == OFF_LOAD) begin
                countdown <= item.write_data[23:0];
              end else if (off == OFF_TICK) begin
                tick_setup <= 10'(apply_alias(32'(tick_setup), {22'd0, item.write_data[9:0]},
                                              alias_sel));
              end
            end
            if (adv) begin
              tick_total <= tick_total + 32'(ticks);
              if (adv_div) begin
                phase <= rem;
              end
              if (count_down) begin
                countdown <= cd_next;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // divider datapath, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      item <= req;
      rem  <= '0;
      quo  <= (req_div == 9'd0) ? SUM_W'(cyc) : req_sum;
    end else if (state == ST_DIV) begin
      if (!diff[9]) begin
        rem <= diff[8:0];
      end else begin
        rem <= trial[8:0];
      end
      quo <= {quo[SUM_W-2:0], !diff[9]};
    end
  end

  // scratch words and output register
  always_ff @(posedge clk) begin
    if (finish) begin
      if ((item.command == CMD_WRITE) && scr_hit) begin
        scratch[scr_idx] <= item.write_data;
      end
      rsp.read_data      <= (item.command == CMD_READ) ? rd_val : 32'd0;
      rsp.watchdog_reset <= adv && fired;
      rsp.tick_count     <= adv ? (tick_total + 32'(ticks)) : tick_total;
    end
  end

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    take |=> (state != ST_IDLE))
    else $error("accepted request did not start processing");

  a_fire_at_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.watchdog_reset) |-> (countdown == 24'd0))
    else $error("watchdog reset reported with countdown not at zero");

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.tick_count == tick_total))
    else $error("reported tick count differs from running total");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (32'(step) < SUM_W))
    else $error("divider step counter overran");

  a_fin_held: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && rsp_valid && rsp_stall) |=> (state == ST_FIN))
    else $error("result completed while output register was occupied");

endmodule
